FILE: rtl/core/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types, sizes and codes for the positional list insert/remove core.
// ----------------------------------------------------------------------------
package pli_pkg;

  // list size and derived widths
  localparam int DEPTH   = 128;
  localparam int POS_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int INDEX_W = 7;
  localparam int LEN_W   = 8;
  localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // place codes
  localparam logic [1:0] PLACE_HEAD  = 2'd0;
  localparam logic [1:0] PLACE_INDEX = 2'd1;
  localparam logic [1:0] PLACE_TAIL  = 2'd2;
  localparam logic [1:0] PLACE_BAD   = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic              en;
    logic              ins;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] value;
  } cell_cmd_t;

endpackage

FILE: rtl/core/pli_cell.sv
// ----------------------------------------------------------------------------
// pli_cell
// One list slot: holds an entry, shifts it with its neighbors on insert and
// remove, and passes a removed word toward slot zero through a tap stage.
// ----------------------------------------------------------------------------
module pli_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pli_pkg::cell_cmd_t          cmd,
  input  logic [pli_pkg::POS_W-1:0]   cell_idx,
  input  logic [pli_pkg::WORD_W-1:0]  left_word,
  input  logic [pli_pkg::WORD_W-1:0]  right_word,
  input  logic [pli_pkg::WORD_W-1:0]  right_tap,
  input  logic                        right_tok,
  output logic [pli_pkg::WORD_W-1:0]  word,
  output logic [pli_pkg::WORD_W-1:0]  tap,
  output logic                        tok
);

  logic [pli_pkg::WORD_W-1:0] word_r, word_nxt;
  logic [pli_pkg::WORD_W-1:0] tap_r, tap_nxt;
  logic                       tok_r, tok_nxt;
  logic                       at_pos, past_pos;

  // position compare against the broadcast command
  assign at_pos   = (cell_idx == cmd.pos);
  assign past_pos = (cell_idx > cmd.pos);

  // entry update: open a gap on insert, close it on remove
  always_comb begin
    word_nxt = word_r;
    if (cmd.en && cmd.ins) begin
      if (past_pos) begin
        word_nxt = left_word;
      end else if (at_pos) begin
        word_nxt = cmd.value;
      end
    end else if (cmd.en && !cmd.ins) begin
      if (past_pos || at_pos) begin
        word_nxt = right_word;
      end
    end
  end

  // removed word enters the tap chain here, otherwise the chain moves left
  always_comb begin
    tap_nxt = right_tap;
    tok_nxt = right_tok;
    if (cmd.en && !cmd.ins && at_pos) begin
      tap_nxt = word_r;
      tok_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    tap_r  <= tap_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign word = word_r;
  assign tap  = tap_r;
  assign tok  = tok_r;

endmodule

FILE: rtl/core/positional_list_insert_remove_core.sv
// ----------------------------------------------------------------------------
// positional_list_insert_remove_core
// Ordered list of 32-bit words in a row of shifting cells, with insert and
// remove at head, index or tail, and status for refused commands.
// ----------------------------------------------------------------------------
// An insert, and any refused command, returns its result in the cycle after the
// start transaction and leaves busy low, so such commands can be issued every
// cycle. A removal at list position p returns its result once the removed word
// has walked one cell per cycle along the tap chain from cell p to cell zero.
// Busy stays high up to and including the cycle of the result strobe, so the
// next command is taken in the cycle after that strobe.
// Each result is shown for a single cycle with out_valid and must be taken then.
module positional_list_insert_remove_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [1:0]                    in_place,
  input  logic [pli_pkg::INDEX_W-1:0]   in_index,
  input  logic [pli_pkg::WORD_W-1:0]    in_value,
  output logic                          out_valid,
  output logic [pli_pkg::WORD_W-1:0]    out_removed_value,
  output logic [1:0]                    out_status,
  output logic [pli_pkg::LEN_W-1:0]     out_length_after
);

  logic                          accept;
  logic [pli_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [1:0]                    status_r, status_nxt;
  logic [pli_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [pli_pkg::CMP_W-1:0]     cnt_ext, idx_ext;
  logic [pli_pkg::CMP_W-1:0]     pos_ext;
  logic                          do_ins, do_rem;
  logic [1:0]                    status;
  pli_pkg::cell_cmd_t            cmd;

  logic [pli_pkg::WORD_W-1:0]    words [pli_pkg::DEPTH];
  logic [pli_pkg::WORD_W-1:0]    taps  [pli_pkg::DEPTH];
  logic                          toks  [pli_pkg::DEPTH];

  assign accept  = start && !busy_r;
  assign cnt_ext = pli_pkg::CMP_W'(count_r);
  assign idx_ext = pli_pkg::CMP_W'(in_index);

  // command decode and bounds checks
  always_comb begin
    status  = pli_pkg::ST_DONE;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    pos_ext = '0;
    if (in_place == pli_pkg::PLACE_BAD) begin
      status = pli_pkg::ST_RANGE;
    end else if (in_op == pli_pkg::OP_INSERT) begin
      if (count_r == pli_pkg::CNT_W'(pli_pkg::DEPTH)) begin
        status = pli_pkg::ST_FULL;
      end else if (in_place == pli_pkg::PLACE_INDEX && idx_ext > cnt_ext) begin
        status = pli_pkg::ST_RANGE;
      end else begin
        do_ins = 1'b1;
        if (in_place == pli_pkg::PLACE_TAIL) begin
          pos_ext = cnt_ext;
        end else if (in_place == pli_pkg::PLACE_INDEX) begin
          pos_ext = idx_ext;
        end
      end
    end else begin
      if (count_r == '0) begin
        status = pli_pkg::ST_EMPTY;
      end else if (in_place == pli_pkg::PLACE_INDEX && idx_ext >= cnt_ext) begin
        status = pli_pkg::ST_RANGE;
      end else begin
        do_rem = 1'b1;
        if (in_place == pli_pkg::PLACE_TAIL) begin
          pos_ext = cnt_ext - pli_pkg::CMP_W'(1);
        end else if (in_place == pli_pkg::PLACE_INDEX) begin
          pos_ext = idx_ext;
        end
      end
    end
  end

  assign cmd.en    = accept && (do_ins || do_rem);
  assign cmd.ins   = do_ins;
  assign cmd.pos   = pos_ext[pli_pkg::POS_W-1:0];
  assign cmd.value = in_value;

  // row of cells
  for (genvar i = 0; i < pli_pkg::DEPTH; i++) begin : g_cell
    logic [pli_pkg::WORD_W-1:0] left_word, right_word, right_tap;
    logic                       right_tok;

    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid
      assign left_word = words[i-1];
    end

    if (i == pli_pkg::DEPTH - 1) begin : g_last
      assign right_word = '0;
      assign right_tap  = '0;
      assign right_tok  = 1'b0;
    end else begin : g_inner
      assign right_word = words[i+1];
      assign right_tap  = taps[i+1];
      assign right_tok  = toks[i+1];
    end

    pli_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .cell_idx   (pli_pkg::POS_W'(i)),
      .left_word  (left_word),
      .right_word (right_word),
      .right_tap  (right_tap),
      .right_tok  (right_tok),
      .word       (words[i]),
      .tap        (taps[i]),
      .tok        (toks[i])
    );
  end

  // count, busy and result registers
  always_comb begin
    count_nxt  = count_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    status_nxt = status_r;
    len_nxt    = len_r;
    if (toks[0]) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      if (do_ins) begin
        count_nxt = count_r + pli_pkg::CNT_W'(1);
      end else if (do_rem) begin
        count_nxt = count_r - pli_pkg::CNT_W'(1);
      end
      status_nxt = status;
      len_nxt    = count_nxt[pli_pkg::LEN_W-1:0];
      if (do_rem) begin
        busy_nxt = 1'b1;
      end else begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    len_r    <= len_nxt;
  end

  // result ports
  assign busy              = busy_r;
  assign out_valid         = done_r || toks[0];
  assign out_removed_value = toks[0] ? taps[0] : '0;
  assign out_status        = status_r;
  assign out_length_after  = len_r;

  // checks
  a_one_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_r && toks[0]))
    else $error("immediate result and removal result in the same cycle");

  a_token_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    toks[0] |-> busy_r)
    else $error("removed word arrived with no removal pending");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("immediate result while a removal is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pli_pkg::CNT_W'(pli_pkg::DEPTH))
    else $error("entry count above list depth");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && do_ins) |=> (count_r == $past(count_r) + pli_pkg::CNT_W'(1)))
    else $error("insert did not add one entry");

endmodule
